// ===== rtl/swlrl_pkg.sv =====
`timescale 1ns / 1ps

package swlrl_pkg;

  localparam int USERS     = 16;
  localparam int LOG_DEPTH = 8;
  localparam int TIME_BITS = 32;

  localparam int USER_ID_W   = 4;
  localparam int IN_WINDOW_W = 4;
  localparam int MAX_REQ_W   = 4;
  localparam int WINDOW_W    = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int USER_W = $clog2(USERS);
  localparam int SLOT_W = $clog2(LOG_DEPTH);
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int ADDR_W = USER_W + SLOT_W;

  localparam int RESET_MAX_REQ = 3;
  localparam int RESET_WINDOW  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_REQUESTS = 1'b0,
    REG_WINDOW_TICKS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DECIDE
  } state_t;

  // per-user ring pointer and fill count
  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } meta_t;

  typedef struct packed {
    logic              en;
    logic [USER_W-1:0] user;
    meta_t             meta;
  } meta_wr_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == SLOT_W'(LOG_DEPTH - 1)) res = '0;
    else res = slot + SLOT_W'(1);
    return res;
  endfunction

  // (head + cnt) mod LOG_DEPTH; cnt never exceeds LOG_DEPTH
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] head,
                                                 input logic [CNT_W-1:0]  cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
    if (sum >= (CNT_W+1)'(LOG_DEPTH)) sum = sum - (CNT_W+1)'(LOG_DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/swlrl_stamp_ram.sv =====
`timescale 1ns / 1ps

module swlrl_stamp_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/swlrl_meta.sv =====
`timescale 1ns / 1ps

module swlrl_meta (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [swlrl_pkg::USER_W-1:0] rd_user,
  output swlrl_pkg::meta_t          rd_meta,
  input  swlrl_pkg::meta_wr_t       wr
);

  import swlrl_pkg::*;

  meta_t table_q [USERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USERS; i++) begin
        table_q[i] <= '0;
      end
    end else if (wr.en) begin
      table_q[wr.user] <= wr.meta;
    end
  end

  assign rd_meta = table_q[rd_user];

  // a count above the ring size would corrupt the scan
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> wr.meta.count <= CNT_W'(LOG_DEPTH))
    else $error("meta count beyond ring depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> 32'(wr.meta.head) < LOG_DEPTH)
    else $error("meta head beyond ring depth");

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> table_q[$past(wr.user)] == $past(wr.meta))
    else $error("meta write lost");

endmodule

// ===== rtl/sliding_window_log_rate_limiter.sv =====
`timescale 1ns / 1ps

// Per-user sliding-window-log rate limiter. A tick (op 0) advances the 32-bit
// time counter, with no response. A request (op 1) for user_id scans that user's
// ring of logged stamps in the stamp RAM, one stamp per cycle through its single
// registered read port, dropping expired stamps, then logs the current time if
// the user is under max_requests (capped at the ring depth) and returns
// allowed/in_window. The scan reads every expired stamp plus the first live
// one, at most 8 stamps. The response sits in an output register, so the next
// request is taken while it waits. Config writes are accepted every cycle and
// belong to idle periods. No clearing pass after reset: per-user counts reset
// in flops.
module sliding_window_log_rate_limiter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [swlrl_pkg::USER_ID_W-1:0]    user_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               allowed,
  output logic [swlrl_pkg::IN_WINDOW_W-1:0]  in_window,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swlrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swlrl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import swlrl_pkg::*;

  state_t state, state_next;

  logic [USER_W-1:0]    user, user_next;
  logic [SLOT_W-1:0]    head, head_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 bad, bad_next;
  logic [TIME_BITS-1:0] time_now;
  logic [MAX_REQ_W-1:0] max_req;
  logic [WINDOW_W-1:0]  window;

  logic                   out_load;
  logic                   allowed_next;
  logic [IN_WINDOW_W-1:0] in_window_next;

  logic [ADDR_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;

  meta_t    rd_meta;
  meta_wr_t meta_wr;

  logic                 user_oor;
  logic [CNT_W-1:0]     start_cnt;
  logic [CNT_W-1:0]     limit;
  logic [TIME_BITS-1:0] age;

  swlrl_stamp_ram #(
    .DATA_W(TIME_BITS),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(time_now),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  swlrl_meta u_meta (
    .clk    (clk),
    .rst    (rst),
    .rd_user(user_id[USER_W-1:0]),
    .rd_meta(rd_meta),
    .wr     (meta_wr)
  );

  assign cfg_ready = 1'b1;
  assign user_oor  = 32'(user_id) >= 32'(USERS);
  assign start_cnt = (rd_meta.count > CNT_W'(LOG_DEPTH)) ? CNT_W'(LOG_DEPTH) : rd_meta.count;
  assign limit     = (32'(max_req) > LOG_DEPTH) ? CNT_W'(LOG_DEPTH) : CNT_W'(max_req);
  assign age       = time_now - rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      time_now  <= '0;
      max_req   <= MAX_REQ_W'(RESET_MAX_REQ);
      window    <= WINDOW_W'(RESET_WINDOW);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready && op == OP_TICK) begin
        time_now <= time_now + TIME_BITS'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAX_REQUESTS: max_req <= cfg_data[MAX_REQ_W-1:0];
          REG_WINDOW_TICKS: window  <= cfg_data[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    user <= user_next;
    head <= head_next;
    cnt  <= cnt_next;
    bad  <= bad_next;
    if (out_load) begin
      allowed   <= allowed_next;
      in_window <= in_window_next;
    end
  end

  always_comb begin
    state_next     = state;
    user_next      = user;
    head_next      = head;
    cnt_next       = cnt;
    bad_next       = bad;
    in_ready       = 1'b0;
    rd_addr        = {user, slot_inc(head)};
    wr_en          = 1'b0;
    wr_addr        = {user, slot_add(head, cnt)};
    meta_wr        = '0;
    out_load       = 1'b0;
    allowed_next   = 1'b0;
    in_window_next = '0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // fetch the oldest stamp alongside the accept
        rd_addr  = {user_id[USER_W-1:0], rd_meta.head};
        if (in_valid && op == OP_REQUEST) begin
          user_next = user_id[USER_W-1:0];
          head_next = rd_meta.head;
          cnt_next  = start_cnt;
          bad_next  = user_oor;
          if (user_oor || start_cnt == '0) state_next = S_DECIDE;
          else state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (age >= TIME_BITS'(window)) begin
          head_next = slot_inc(head);
          cnt_next  = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) state_next = S_DECIDE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (!bad) begin
            meta_wr.en        = 1'b1;
            meta_wr.user      = user;
            meta_wr.meta.head = head;
            if (cnt < limit) begin
              wr_en              = 1'b1;
              meta_wr.meta.count = cnt + CNT_W'(1);
              allowed_next       = 1'b1;
              in_window_next     = IN_WINDOW_W'(cnt + CNT_W'(1));
            end else begin
              meta_wr.meta.count = cnt;
              in_window_next     = IN_WINDOW_W'(cnt);
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_resp_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DECIDE)
    else $error("response raised outside decision");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> cnt != '0 && !bad)
    else $error("scan with empty ring");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_TICK) |=> time_now == $past(time_now) + TIME_BITS'(1))
    else $error("tick lost");

  a_time_frozen_in_scan: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(time_now))
    else $error("time moved during a request");

  a_log_only_under_limit: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> cnt < limit && state == S_DECIDE && out_load)
    else $error("stamp logged over limit");

endmodule

// ===== bench/tb_sliding_window_log_rate_limiter.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_log_rate_limiter;
  import swlrl_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 225;

  typedef struct packed {
    logic                   allowed;
    logic [IN_WINDOW_W-1:0] in_window;
  } verdict_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    op_t                   op;
    logic [USER_ID_W-1:0]  user;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    typed;
    verdict_t              want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op = OP_TICK;
  logic [USER_ID_W-1:0]   user_id = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   allowed;
  logic [IN_WINDOW_W-1:0] in_window;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // mirror of the limiter state
  logic [TIME_BITS-1:0]   m_time = '0;
  logic [TIME_BITS-1:0]   m_stamp [USERS][LOG_DEPTH];
  logic [SLOT_W-1:0]      m_head [USERS];
  logic [CNT_W-1:0]       m_count [USERS];
  logic [MAX_REQ_W-1:0]   m_max = MAX_REQ_W'(RESET_MAX_REQ);
  logic [WINDOW_W-1:0]    m_window = WINDOW_W'(RESET_WINDOW);

  verdict_t verdict_q [$];
  int       fail_cnt = 0;
  int       rx_mode = 1;
  bit       hold_req = 1'b0;

  row_t dir_rows [31] = '{
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd1}},
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd2}},
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd3}},
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b0, 4'd3}},
    '{ROW_ITEM, OP_REQUEST, 4'd15, REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd1}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_WINDOW_TICKS, 16'd1,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_TICK,    4'd10, REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    // one tick on, every stamp of user 0 has aged out
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd1}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_WINDOW_TICKS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    // zero window: even a stamp of the current time expires
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd1}},
    '{ROW_ITEM, OP_REQUEST, 4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b1, 4'd1}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd3,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b0, 4'd0}},
    // limit above ring depth saturates at the depth
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_MAX_REQUESTS, 16'hFFFF,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_WINDOW_TICKS, 16'hFFFF,  1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b0, 4'd8}},
    // lowered limit: logged stamps stay, requests bounce
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_MAX_REQUESTS, 16'd1,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b1, '{1'b0, 4'd8}},
    '{ROW_ITEM, OP_TICK,    4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_WINDOW_TICKS, 16'd1,     1'b0, '{1'b0, 4'd0}},
    '{ROW_ITEM, OP_REQUEST, 4'd5,  REG_MAX_REQUESTS, 16'd0,     1'b0, '{1'b0, 4'd0}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_MAX_REQUESTS, 16'd8,     1'b0, '{1'b0, 4'd0}},
    '{ROW_CFG,  OP_TICK,    4'd0,  REG_WINDOW_TICKS, 16'd10,    1'b0, '{1'b0, 4'd0}}
  };

  sliding_window_log_rate_limiter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .user_id   (user_id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .allowed   (allowed),
    .in_window (in_window),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int u = 0; u < USERS; u++) begin
      m_head[u]  = '0;
      m_count[u] = '0;
    end
  end

  // expire old stamps of one user, then log the current time if under the limit
  function automatic verdict_t log_request(input logic [USER_ID_W-1:0] uid);
    verdict_t             v;
    int                   hd;
    int                   cnt;
    int                   lim;
    logic [TIME_BITS-1:0] age;
    hd  = m_head[uid];
    cnt = m_count[uid];
    while (cnt > 0) begin
      age = m_time - m_stamp[uid][hd];
      if (age >= TIME_BITS'(m_window)) begin
        hd = (hd + 1) % LOG_DEPTH;
        cnt--;
      end else begin
        break;
      end
    end
    lim = (m_max > LOG_DEPTH) ? LOG_DEPTH : int'(m_max);
    v.allowed = 1'b0;
    if (cnt < lim) begin
      m_stamp[uid][(hd + cnt) % LOG_DEPTH] = m_time;
      cnt++;
      v.allowed = 1'b1;
    end
    m_head[uid]  = SLOT_W'(hd);
    m_count[uid] = CNT_W'(cnt);
    v.in_window  = IN_WINDOW_W'(cnt);
    return v;
  endfunction

  task automatic push_item(input op_t o, input logic [USER_ID_W-1:0] uid,
                           input bit typed, input verdict_t typed_v);
    logic     hs;
    verdict_t v;
    cfg_valid <= 1'b0;
    in_valid  <= 1'b1;
    op        <= o;
    user_id   <= uid;
    forever begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
      if (hs) break;
    end
    if (o == OP_TICK) begin
      m_time = m_time + 1'b1;
    end else begin
      v = log_request(uid);
      verdict_q.push_back(typed ? typed_v : v);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    logic hs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
      if (hs) break;
    end
    if (idx == REG_MAX_REQUESTS) m_max = val[MAX_REQ_W-1:0];
    else m_window = val[WINDOW_W-1:0];
  endtask

  // ticks give no response, so allow the block to finish one before a write
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // response checker
  always @(negedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected response: allowed %0d in_window %0d", allowed, in_window);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (allowed !== want.allowed) begin
          $error("allowed: expected %0d, got %0d", want.allowed, allowed);
          fail_cnt++;
        end
        if (in_window !== want.in_window) begin
          $error("in_window: expected %0d, got %0d", want.in_window, in_window);
          fail_cnt++;
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    int unsigned rx_cyc;
    rx_cyc = 0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cyc % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // watchdog on cycles with no accepted transfer
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int                    burst;
    int                    gap;
    int                    base;
    op_t                   o;
    logic [USER_ID_W-1:0]  uid;
    logic [CFG_DATA_W-1:0] max_val;
    logic [CFG_DATA_W-1:0] win_val;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
      end else begin
        push_item(dir_rows[i].op, dir_rows[i].user, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      // limit mostly in range, upper data bits random
      case ($urandom_range(0, 9))
        0:       max_val = 16'd0;
        1, 2:    max_val = CFG_DATA_W'($urandom_range(9, 15));
        default: max_val = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      max_val[CFG_DATA_W-1:MAX_REQ_W] = (CFG_DATA_W-MAX_REQ_W)'($urandom());
      case ($urandom_range(0, 9))
        0:       win_val = 16'd0;
        1:       win_val = 16'd1;
        2:       win_val = 16'hFFFF;
        3:       win_val = CFG_DATA_W'($urandom());
        4, 5:    win_val = CFG_DATA_W'($urandom_range(13, 40));
        default: win_val = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_MAX_REQUESTS, max_val);
        write_reg(REG_WINDOW_TICKS, win_val);
      end else begin
        write_reg(REG_WINDOW_TICKS, win_val);
        write_reg(REG_MAX_REQUESTS, max_val);
      end
      rx_mode = (ph == 0) ? 0 : $urandom_range(0, 3);
      if (ph == 2) hold_req = 1'b1;
      base  = $urandom_range(0, 12);
      burst = $urandom_range(1, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        o = ($urandom_range(0, 9) < 4) ? OP_TICK : OP_REQUEST;
        // most requests land on a few users so the logs fill and expire
        if ($urandom_range(0, 9) < 7) uid = USER_ID_W'(base + $urandom_range(0, 3));
        else uid = USER_ID_W'($urandom_range(0, USERS - 1));
        push_item(o, uid, 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (ph == 0) gap = 0;
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    settle();
    if (fail_cnt == 0 && verdict_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
